@@ hw/rtl/weighted_thread_range_split_top_macros.svh @@
// assertion helpers for the range split block
// both sample on clk_i and are off while rst_ni is low
`ifndef WEIGHTED_THREAD_RANGE_SPLIT_TOP_MACROS_SVH
`define WEIGHTED_THREAD_RANGE_SPLIT_TOP_MACROS_SVH

// consequent checked in the same cycle
`define WTRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define WTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wtrs_pkg.sv @@
package wtrs_pkg;

  localparam int unsigned MAX_REQUESTS = 64;
  localparam int unsigned MAX_THREADS  = 256;

  localparam int unsigned N_W   = 7;   // request count
  localparam int unsigned IDX_W = 6;   // request index
  localparam int unsigned T_W   = 9;   // thread count, minimum, demand, end
  localparam int unsigned S_W   = 8;   // range start
  localparam int unsigned TOT_W = 12;  // total weight, cumulative weight
  localparam int unsigned DIV_W = 20;  // divider numerator and quotient
  localparam int unsigned CNT_W = 5;   // divider step counter

  localparam logic [T_W-1:0] THREAD_COUNT_RST = 9'd8;
  localparam logic [T_W-1:0] MIN_THREADS_RST  = 9'd1;

  // configuration register indexes
  localparam logic REG_THREAD_COUNT = 1'b0;
  localparam logic REG_MIN_THREADS  = 1'b1;

  typedef enum logic {
    DIV_DEMAND,
    DIV_START
  } wtrs_div_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEM_GO,
    ST_DEM_WAIT,
    ST_STA_GO,
    ST_STA_WAIT,
    ST_EMIT
  } wtrs_state_e;

  typedef struct packed {
    logic          load;
    logic          div_start;
    wtrs_div_sel_e div_sel;
    logic          latch_dem;
    logic          latch_sta;
    logic          emit;
  } wtrs_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic div_done;
    logic out_free;
    logic is_last;
  } wtrs_sts_t;

endpackage

@@ hw/rtl/weighted_thread_range_split_top.sv @@
// a nonzero count keeps the input stalled until the last result of its list is emitted
// each result needs two 20-step divisions, demand then start, on one shared divider
// reset: asynchronous, active low; thread_count goes to 8, min_threads to 1
// a zero request count is taken and gives no result
module weighted_thread_range_split_top import wtrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration writes
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [T_W-1:0]   cfg_data_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [N_W-1:0]   active_requests_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IDX_W-1:0] request_index_o,
  output logic [S_W-1:0]   range_start_o,
  output logic [T_W-1:0]   range_end_o,
  output logic             last_o
);

  // command and status between the sequencer and the datapath
  wtrs_cmd_t cmd;
  wtrs_sts_t sts;

  // sequencer: per request, demand division, start division, then emit
  wtrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: config registers, weight bookkeeping, divider, output register
  // the output register lets the next division run while a result waits
  wtrs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .active_requests_i (active_requests_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .request_index_o   (request_index_o),
    .range_start_o     (range_start_o),
    .range_end_o       (range_end_o),
    .last_o            (last_o)
  );

endmodule

@@ hw/rtl/wtrs_div.sv @@
module wtrs_div import wtrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [TOT_W-1:0] den_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TOT_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [TOT_W-1:0] den_q, den_d;
  logic [TOT_W:0]   trial;
  logic [TOT_W:0]   diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ hw/rtl/wtrs_datapath.sv @@
module wtrs_datapath import wtrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [T_W-1:0]   cfg_data_i,
  input  logic [N_W-1:0]   active_requests_i,
  input  logic             out_stall_i,
  input  wtrs_cmd_t        cmd_i,
  output wtrs_sts_t        sts_o,
  output logic             out_valid_o,
  output logic [IDX_W-1:0] request_index_o,
  output logic [S_W-1:0]   range_start_o,
  output logic [T_W-1:0]   range_end_o,
  output logic             last_o
);

  logic [T_W-1:0]   thread_count_q, min_threads_q;
  logic [N_W-1:0]   n_q, n_sat;
  logic [T_W-1:0]   t_q, t_sat;
  logic [T_W-1:0]   m_q, m_eff;
  logic [TOT_W-1:0] total_q, cum_q;
  logic [IDX_W-1:0] idx_q;
  logic [T_W-1:0]   dem_q, dem_d;
  logic [S_W-1:0]   sta_q;
  logic [13:0]      tot_prod;
  logic [N_W-1:0]   w;
  logic [15:0]      dem_prod;
  logic [20:0]      sta_prod;
  logic [DIV_W-1:0] dem_num, sta_num, div_num;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [T_W:0]     end_full;
  logic [T_W-1:0]   end_val;
  logic [T_W-1:0]   end_less;
  logic [S_W-1:0]   start_val;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [S_W-1:0]   out_start_q;
  logic [T_W-1:0]   out_end_q;
  logic             out_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thread_count_q <= THREAD_COUNT_RST;
      min_threads_q  <= MIN_THREADS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THREAD_COUNT: thread_count_q <= cfg_data_i;
        REG_MIN_THREADS:  min_threads_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item setup
  assign n_sat    = (active_requests_i > N_W'(MAX_REQUESTS)) ? N_W'(MAX_REQUESTS)
                                                             : active_requests_i;
  assign t_sat    = (thread_count_q > T_W'(MAX_THREADS)) ? T_W'(MAX_THREADS)
                                                         : thread_count_q;
  assign m_eff    = (min_threads_q == '0) ? T_W'(1) : min_threads_q;
  assign tot_prod = {7'd0, n_sat} * ({7'd0, n_sat} + 14'd1);

  // numerators: ceil for the demand, floor for the start
  assign w        = n_q - {1'b0, idx_q};
  assign dem_prod = {7'd0, t_q} * {9'd0, w};
  assign sta_prod = {12'd0, t_q} * {9'd0, cum_q};
  assign dem_num  = {4'd0, dem_prod} + {8'd0, total_q} - 20'd1;
  assign sta_num  = sta_prod[DIV_W-1:0];
  assign div_num  = (cmd_i.div_sel == DIV_START) ? sta_num : dem_num;

  wtrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (total_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign dem_d = (div_quo[T_W-1:0] < m_q) ? m_q : div_quo[T_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= n_sat;
      t_q     <= t_sat;
      m_q     <= m_eff;
      total_q <= tot_prod[TOT_W:1];
      idx_q   <= '0;
      cum_q   <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + IDX_W'(1);
      cum_q <= cum_q + {5'd0, w};
    end
    if (cmd_i.latch_dem) dem_q <= dem_d;
    if (cmd_i.latch_sta) sta_q <= div_quo[S_W-1:0];
  end

  // clip the range at the thread count and pull the start down
  assign end_full = {2'd0, sta_q} + {1'b0, dem_q};
  assign end_val  = (end_full > {1'b0, t_q}) ? t_q : end_full[T_W-1:0];
  assign end_less = end_val - dem_q;
  always_comb begin
    if (end_val >= dem_q) begin
      start_val = ({1'b0, sta_q} > end_less) ? end_less[S_W-1:0] : sta_q;
    end else begin
      start_val = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q   <= idx_q;
      out_start_q <= start_val;
      out_end_q   <= end_val;
      out_last_q  <= sts_o.is_last;
    end
  end

  assign sts_o.in_zero  = (active_requests_i == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.is_last  = ({1'b0, idx_q} == (n_q - N_W'(1)));

  assign out_valid_o     = out_valid_q;
  assign request_index_o = out_idx_q;
  assign range_start_o   = out_start_q;
  assign range_end_o     = out_end_q;
  assign last_o          = out_last_q;

endmodule

@@ hw/rtl/wtrs_ctrl.sv @@
module wtrs_ctrl import wtrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  wtrs_sts_t sts_i,
  output wtrs_cmd_t cmd_o
);

  wtrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        // a count of zero is taken and gives no result
        if (in_valid_i && !sts_i.in_zero) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DEM_GO;
        end
      end
      ST_DEM_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DEMAND;
        state_d         = ST_DEM_WAIT;
      end
      ST_DEM_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_dem = 1'b1;
          state_d         = ST_STA_GO;
        end
      end
      ST_STA_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_START;
        state_d         = ST_STA_WAIT;
      end
      ST_STA_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_sta = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.is_last ? ST_IDLE : ST_DEM_GO;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/wtrs_checker.sv @@
`include "weighted_thread_range_split_top_macros.svh"

module wtrs_checker import wtrs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic             cfg_idx_i,
  input logic [T_W-1:0]   cfg_data_i,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [N_W-1:0]   active_requests_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [IDX_W-1:0] request_index_o,
  input logic [S_W-1:0]   range_start_o,
  input logic [T_W-1:0]   range_end_o,
  input logic             last_o
);

  // stalled result holds
  `WTRS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(range_start_o) && $stable(range_end_o) && $stable(request_index_o) && $stable(last_o), "stalled result changed")

  // a nonzero count keeps the block busy in the next cycle
  `WTRS_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o && (active_requests_i != '0), in_stall_o, "block not busy after taking a request count")

  // a range never runs backward
  `WTRS_ASSERT_NOW(a_range_order, out_valid_o, {1'b0, range_start_o} <= range_end_o, "range start above range end")

  // no range ends beyond the thread limit
  `WTRS_ASSERT_NOW(a_end_limit, out_valid_o, range_end_o <= T_W'(MAX_THREADS), "range end above thread limit")

  // the highest request index is always the final one
  `WTRS_ASSERT_NOW(a_last_index, out_valid_o && (request_index_o == IDX_W'(MAX_REQUESTS - 1)), last_o, "last request not marked")

endmodule

bind weighted_thread_range_split_top wtrs_checker u_wtrs_checker (.*);

@@ tb/sv/weighted_thread_range_split_top_tb.sv @@
`timescale 1ns / 1ps

module weighted_thread_range_split_top_tb import wtrs_pkg::*;;

  // run length and pacing
  localparam int RAND_ITEMS = 200;
  localparam int PHASE_LEN  = 40;    // random items between register changes
  localparam int SETTLE     = 60;    // a bit more than the first-result latency
  localparam int RX_HOLD    = 1000;  // long receiver hold-off, in cycles
  localparam int LIMIT      = 4_000_000;
  localparam int N_ROWS     = 31;

  // one expected range, in the order the block hands them out
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [S_W-1:0]   lo;
    logic [T_W-1:0]   hi;
    logic             last;
  } thread_range_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_e;

  // directed row: a register write or a request count, with an optional
  // hand-typed range that every result of the row must carry
  typedef struct packed {
    row_kind_e        kind;
    logic             reg_sel;
    logic [T_W-1:0]   value;
    logic [N_W-1:0]   count;
    logic             typed;
    logic [S_W-1:0]   lo;
    logic [T_W-1:0]   hi;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // reset values: eight threads, minimum one
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd1,   1'b1, 8'd0, 9'd8},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd0,   1'b1, 8'd0, 9'd0},  // no result
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd2,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd64,  1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd127, 1'b0, 8'd0, 9'd0},  // saturates
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd65,  1'b0, 8'd0, 9'd0},
    // largest pool
    '{ROW_WRITE, REG_THREAD_COUNT, 9'd256, 7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd1,   1'b1, 8'd0, 9'd256},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd64,  1'b0, 8'd0, 9'd0},
    // pool above the maximum is clipped to 256
    '{ROW_WRITE, REG_THREAD_COUNT, 9'd511, 7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd1,   1'b1, 8'd0, 9'd256},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd37,  1'b0, 8'd0, 9'd0},
    // empty pool: every range collapses to zero
    '{ROW_WRITE, REG_THREAD_COUNT, 9'd0,   7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd5,   1'b1, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd127, 1'b1, 8'd0, 9'd0},
    // single thread, minimum zero taken as one
    '{ROW_WRITE, REG_THREAD_COUNT, 9'd1,   7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_WRITE, REG_MIN_THREADS,  9'd0,   7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd1,   1'b1, 8'd0, 9'd1},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd3,   1'b0, 8'd0, 9'd0},
    // minimum far above the pool: ranges clipped and overlapping
    '{ROW_WRITE, REG_MIN_THREADS,  9'd511, 7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd4,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd1,   1'b1, 8'd0, 9'd1},
    '{ROW_WRITE, REG_THREAD_COUNT, 9'd200, 7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_WRITE, REG_MIN_THREADS,  9'd256, 7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd2,   1'b0, 8'd0, 9'd0},
    // minimum that bites only on the light requests, then a saturating count with minimum one
    '{ROW_WRITE, REG_THREAD_COUNT, 9'd64,  7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_WRITE, REG_MIN_THREADS,  9'd5,   7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd10,  1'b0, 8'd0, 9'd0},
    '{ROW_WRITE, REG_THREAD_COUNT, 9'd255, 7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_WRITE, REG_MIN_THREADS,  9'd1,   7'd0,   1'b0, 8'd0, 9'd0},
    '{ROW_ITEM,  REG_THREAD_COUNT, 9'd0,   7'd85,  1'b0, 8'd0, 9'd0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_THREAD_COUNT;
  logic [T_W-1:0]   cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [N_W-1:0]   active_requests_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [IDX_W-1:0] request_index_o;
  logic [S_W-1:0]   range_start_o;
  logic [T_W-1:0]   range_end_o;
  logic             last_o;

  // shadow copies of the two registers
  logic [T_W-1:0]   shadow_threads = THREAD_COUNT_RST;
  logic [T_W-1:0]   shadow_min = MIN_THREADS_RST;

  thread_range_t    expected_ranges [$];
  int               errors = 0;
  int               tx_sent = 0;
  bit               tx_burst = 1'b0;
  bit               rx_burst = 1'b0;
  bit               rx_hold_req = 1'b0;

  weighted_thread_range_split_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .active_requests_i (active_requests_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .request_index_o   (request_index_o),
    .range_start_o     (range_start_o),
    .range_end_o       (range_end_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // append one expected range at the tail of the queue
  function automatic void queue_range(input logic [IDX_W-1:0] idx,
                                      input logic [S_W-1:0] lo,
                                      input logic [T_W-1:0] hi,
                                      input logic fin_flag);
    thread_range_t rng;
    rng.idx  = idx;
    rng.lo   = lo;
    rng.hi   = hi;
    rng.last = fin_flag;
    expected_ranges.insert(expected_ranges.size(), rng);
  endfunction

  // weighted split: request i of n weighs n-i out of n(n+1)/2
  function automatic void split_ranges(input logic [N_W-1:0] cnt);
    int unsigned n, t, m, total, cum, w, dem, st, fin;
    n = cnt;
    if (n == 0) return;
    if (n > MAX_REQUESTS) n = MAX_REQUESTS;
    t = shadow_threads;
    if (t > MAX_THREADS) t = MAX_THREADS;
    m = (shadow_min == 0) ? 1 : shadow_min;
    total = n * (n + 1) / 2;
    cum = 0;
    for (int unsigned i = 0; i < n; i++) begin
      w = n - i;
      dem = (t * w + total - 1) / total;  // ceiling share
      st = (t * cum) / total;             // floor of the cumulative share
      if (dem < m) dem = m;
      fin = st + dem;
      if (fin > t) fin = t;
      // pull the start down so the range keeps its demand where it can
      if (fin >= dem) begin
        if (st > fin - dem) st = fin - dem;
      end else begin
        st = 0;
      end
      queue_range(IDX_W'(i), S_W'(st), T_W'(fin), i + 1 == n);
      cum += w;
    end
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // one register write; the enable is high for a single cycle
  task automatic set_register(input logic sel, input logic [T_W-1:0] val);
    cfg_idx_i <= sel;
    cfg_data_i <= val;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    if (sel == REG_THREAD_COUNT) shadow_threads = val;
    else shadow_min = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one request count and return once the block no longer stalls the input;
  // valid stays up so a back-to-back count is offered without a break in valid
  task automatic send_count(input logic [N_W-1:0] cnt, input bit rush);
    int gap;
    if (tx_sent % 16 == 0) tx_burst = ($urandom_range(0, 2) == 0);
    tx_sent++;
    gap = (rush || tx_burst) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    active_requests_i <= cnt;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // stop offering, wait for every range, then let the block settle
  task automatic drain_ranges();
    in_valid_i <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // result side: random stall per result, one long hold-off on request
  initial begin : range_sink
    thread_range_t want;
    int hold;
    int taken;
    taken = 0;
    forever begin
      if (taken % 20 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      if (rx_hold_req) begin
        hold = RX_HOLD;
        rx_hold_req = 1'b0;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      taken++;
      if (expected_ranges.size() == 0) begin
        flag_error($sformatf("unexpected range idx %0d start %0d end %0d last %0b",
                             request_index_o, range_start_o, range_end_o, last_o));
      end else begin
        want = expected_ranges.pop_front();
        if (request_index_o !== want.idx || range_start_o !== want.lo ||
            range_end_o !== want.hi || last_o !== want.last)
          flag_error($sformatf(
            "exp idx %0d start %0d end %0d last %0b, got idx %0d start %0d end %0d last %0b",
            want.idx, want.lo, want.hi, want.last,
            request_index_o, range_start_o, range_end_o, last_o));
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("weighted_thread_range_split_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    int sat;
    int pick;
    logic [N_W-1:0] cnt;
    logic [T_W-1:0] val;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; writes only once the block has gone quiet
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WRITE) begin
        drain_ranges();
        set_register(row.reg_sel, row.value);
      end else begin
        send_count(row.count, 1'b0);
        if (row.typed) begin
          sat = (row.count > MAX_REQUESTS) ? MAX_REQUESTS : row.count;
          for (int i = 0; i < sat; i++)
            queue_range(IDX_W'(i), row.lo, row.hi, i == sat - 1);
        end else begin
          split_ranges(row.count);
        end
      end
    end

    // random counts, new register settings every phase
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        drain_ranges();
        pick = $urandom_range(0, 5);
        case (pick)
          0: val = '0;
          1: val = 9'd1;
          2: val = 9'd256;
          3: val = 9'd511;
          default: val = T_W'($urandom_range(2, 300));
        endcase
        set_register(REG_THREAD_COUNT, val);
        pick = $urandom_range(0, 5);
        case (pick)
          0: val = '0;
          1: val = 9'd1;
          2: val = T_W'($urandom_range(257, 511));
          default: val = T_W'($urandom_range(2, 20));
        endcase
        set_register(REG_MIN_THREADS, val);
      end
      // receiver holds off while a burst of back-to-back counts waits behind it
      if (k == 70) rx_hold_req = 1'b1;
      // sender waits for every outstanding range before going on
      if (k == 130) drain_ranges();
      // mostly short lists, some empty, a few long and saturating ones
      pick = $urandom_range(0, 99);
      if (pick < 5) cnt = '0;
      else if (pick < 65) cnt = N_W'($urandom_range(1, 8));
      else if (pick < 85) cnt = N_W'($urandom_range(9, 24));
      else if (pick < 93) cnt = N_W'($urandom_range(25, 64));
      else if (pick < 97) cnt = N_W'(MAX_REQUESTS);
      else cnt = N_W'($urandom_range(65, 127));
      send_count(cnt, k >= 70 && k < 82);
      split_ranges(cnt);
    end

    drain_ranges();
    if (errors == 0 && expected_ranges.size() == 0) begin
      $display("weighted_thread_range_split_top_tb: clean");
    end else begin
      $display("weighted_thread_range_split_top_tb: errors");
    end
    $finish;
  end

endmodule
